>>> rtl/particle_swarm_update_assert.svh
// Assertion macros shared by the particle swarm update block.
`ifndef PARTICLE_SWARM_UPDATE_ASSERT_SVH
`define PARTICLE_SWARM_UPDATE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared constants and controller/datapath command types.
// ----------------------------------------------------------------------------
package psu_pkg;
	localparam int NumParticlesDef = 32;
	localparam int NumDimsDef = 2;
	localparam int PosW = 16;
	localparam int FitW = 35;
	localparam int WgtW = 14;
	localparam int LimW = 15;
	localparam int CfgW = 15;
	localparam int CfgIdxW = 2;
	localparam logic [FitW-1:0] FitMax = {FitW{1'b1}};

	localparam logic [CfgIdxW-1:0] RegInertia = 2'd0;
	localparam logic [CfgIdxW-1:0] RegCog = 2'd1;
	localparam logic [CfgIdxW-1:0] RegSoc = 2'd2;
	localparam logic [CfgIdxW-1:0] RegLimit = 2'd3;

	localparam logic OpInit = 1'b0;
	localparam logic OpUpdate = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // latch the item, issue element reads
		logic mult;      // form coefficient and inertia products
		logic sum;       // form the velocity sum and write the element
		logic finish;    // fitness, bests, result strobe
		logic copy;      // copy one element of the best positions
	} psu_cmd_t;

	typedef struct packed {
		logic in_range;
		logic closes;    // item is in range and closes the fitness
		logic is_update;
		logic pimp;
		logic gimp;
	} psu_stat_t;
endpackage

>>> rtl/psu_ctrl.sv
// ----------------------------------------------------------------------------
// psu_ctrl
// Sequencer: steps each item through read, multiply, sum, finish and the
// optional best-position copy sweep.
// ----------------------------------------------------------------------------
module psu_ctrl #(
	parameter int NUM_DIMS = psu_pkg::NumDimsDef,
	parameter int DimW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  psu_pkg::psu_stat_t stat,
	output logic busy,
	output psu_pkg::psu_cmd_t cmd,
	output logic [DimW-1:0] copy_dim
);
	import psu_pkg::*;

	typedef enum logic [2:0] {
		StIdle, StMult, StSum, StFinish, StCopy
	} state_t;

	state_t state_q;
	logic [DimW-1:0] copy_q;

	assign busy = (state_q != StIdle);
	assign copy_dim = copy_q;

	always_comb begin
		cmd = '0;
		cmd.capture = (state_q == StIdle) && start;
		cmd.mult = (state_q == StMult);
		cmd.sum = (state_q == StSum);
		cmd.finish = (state_q == StFinish);
		cmd.copy = (state_q == StCopy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			copy_q <= '0;
		end else begin
			case (state_q)
				StIdle: begin
					if (start) begin
						state_q <= StMult;
					end
				end
				StMult: state_q <= StSum;
				StSum: state_q <= StFinish;
				StFinish: begin
					copy_q <= '0;
					if (stat.closes && (stat.pimp || stat.gimp)) begin
						state_q <= StCopy;
					end else begin
						state_q <= StIdle;
					end
				end
				StCopy: begin
					if (copy_q == DimW'(NUM_DIMS - 1)) begin
						state_q <= StIdle;
					end else begin
						copy_q <= copy_q + 1'b1;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	`include "particle_swarm_update_assert.svh"
	`PSU_ASSERT_NEXT(a_capture_to_mult, clk, arst_n, cmd.capture, cmd.mult)
	`PSU_ASSERT_NEXT(a_mult_to_sum, clk, arst_n, cmd.mult, cmd.sum)
	`PSU_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0(cmd))
endmodule

>>> rtl/psu_datapath.sv
// ----------------------------------------------------------------------------
// psu_datapath
// Element memories, velocity arithmetic, fitness sum and best tracking.
// ----------------------------------------------------------------------------
module psu_datapath #(
	parameter int NUM_PARTICLES = psu_pkg::NumParticlesDef,
	parameter int NUM_DIMS = psu_pkg::NumDimsDef,
	parameter int PartW = 5,
	parameter int DimW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  psu_pkg::psu_cmd_t cmd,
	input  logic [DimW-1:0] copy_dim,
	output psu_pkg::psu_stat_t stat,
	input  logic cfg_we,
	input  logic [psu_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [psu_pkg::CfgW-1:0] cfg_data,
	input  logic op,
	input  logic [4:0] particle,
	input  logic dim,
	input  logic signed [15:0] init_position,
	input  logic signed [15:0] init_velocity,
	input  logic [15:0] rand_cog,
	input  logic [15:0] rand_soc,
	input  logic last_dim,
	output logic done,
	output logic signed [15:0] new_position,
	output logic signed [15:0] new_velocity,
	output logic fitness_valid,
	output logic [34:0] particle_fitness,
	output logic personal_improved,
	output logic global_improved,
	output logic [34:0] global_best_fitness,
	output logic signed [15:0] global_best_at_dim
);
	import psu_pkg::*;

	localparam int NumElems = NUM_PARTICLES * NUM_DIMS;
	localparam int ElemW = (NumElems > 1) ? $clog2(NumElems) : 1;
	localparam int PIdxW = PartW;

	// Configuration registers.
	logic [WgtW-1:0] inertia_q, cog_q, soc_q;
	logic [LimW-1:0] limit_q;

	// Element memories.
	logic signed [PosW-1:0] pos_mem [NumElems];
	logic signed [PosW-1:0] vel_mem [NumElems];
	logic signed [PosW-1:0] pb_mem [NumElems];
	logic [FitW-1:0] pbfit_q [NUM_PARTICLES];
	logic signed [PosW-1:0] gbpos_q [NUM_DIMS];
	logic [FitW-1:0] gbfit_q, acc_q;

	// Item latches.
	logic op_q, last_q, inr_q;
	logic [PIdxW-1:0] p_q;
	logic [DimW-1:0] d_q;
	logic dim_ok_q;
	logic signed [PosW-1:0] ipos_q, ivel_q;
	logic [15:0] r1_q, r2_q;

	logic signed [PosW-1:0] x_q, v_q, pb_q, cp_rd_q;
	logic signed [29:0] kc_q, ks_q;
	logic signed [31:0] iv_q;
	logic signed [PosW:0] dp_q, dg_q;
	logic signed [PosW-1:0] npos_q, nvel_q;
	logic [FitW-1:0] fit_q;
	logic pimp_q, gimp_q;

	logic in_range;
	logic [ElemW-1:0] elem_addr, copy_addr, rd_addr, copy_rd_addr;
	logic [DimW-1:0] copy_rd_dim;
	logic [PosW-1:0] gb_sel;

	assign in_range = (32'(particle) < NUM_PARTICLES) && (32'(dim) < NUM_DIMS);
	assign elem_addr = ElemW'(32'(p_q) * NUM_DIMS + 32'(d_q));
	assign copy_addr = ElemW'(32'(p_q) * NUM_DIMS + 32'(copy_dim));
	// At capture the element is addressed straight from the item so that its
	// data is registered by the time the multiply stage runs.
	assign rd_addr = cmd.capture ?
		ElemW'(32'(PIdxW'(particle)) * NUM_DIMS + 32'(dim)) : elem_addr;
	// The copy sweep reads one element ahead of the one it writes.
	assign copy_rd_dim = cmd.copy ? DimW'(copy_dim + 1'b1) : '0;
	assign copy_rd_addr = ElemW'(32'(p_q) * NUM_DIMS + 32'(copy_rd_dim));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inertia_q <= WgtW'(2048);
			cog_q <= WgtW'(4096);
			soc_q <= WgtW'(4096);
			limit_q <= LimW'(410);
		end else if (cfg_we) begin
			case (cfg_index)
				RegInertia: inertia_q <= cfg_data[WgtW-1:0];
				RegCog: cog_q <= cfg_data[WgtW-1:0];
				RegSoc: soc_q <= cfg_data[WgtW-1:0];
				RegLimit: limit_q <= cfg_data[LimW-1:0];
				default: ;
			endcase
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= op;
			last_q <= last_dim;
			inr_q <= in_range;
			p_q <= PIdxW'(particle);
			d_q <= DimW'(dim);
			dim_ok_q <= (32'(dim) < NUM_DIMS);
			ipos_q <= init_position;
			ivel_q <= init_velocity;
			r1_q <= rand_cog;
			r2_q <= rand_soc;
		end
	end

	// Registered memory reads: the item element and the copy sweep element.
	always_ff @(posedge clk) begin
		x_q <= pos_mem[rd_addr];
		v_q <= vel_mem[rd_addr];
		pb_q <= pb_mem[rd_addr];
		cp_rd_q <= pos_mem[copy_rd_addr];
	end

	// Multiply stage: coefficients, inertia product and differences.
	logic [29:0] kc_full, ks_full;
	assign kc_full = cog_q * r1_q;
	assign ks_full = soc_q * r2_q;
	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			kc_q <= $signed({16'd0, kc_full[29:16]});
			ks_q <= $signed({16'd0, ks_full[29:16]});
			iv_q <= $signed({1'b0, inertia_q}) * v_q;
			dp_q <= pb_q - x_q;
			dg_q <= $signed(gbpos_q[d_q]) - x_q;
		end
	end

	// Sum stage: the two small products stay within 32 bits each.
	logic signed [33:0] sum24, vraw_w;
	logic signed [31:0] pc, pg;
	logic signed [21:0] vraw;
	logic signed [21:0] lim_s;
	logic signed [21:0] vcl;
	logic signed [17:0] psum;
	logic signed [PosW-1:0] npos_w, nvel_w;
	assign pc = 32'(kc_q * dp_q);
	assign pg = 32'(ks_q * dg_q);
	assign sum24 = 34'(iv_q) + 34'(pc) + 34'(pg);
	assign vraw_w = sum24 >>> 12;
	assign vraw = vraw_w[21:0];
	assign lim_s = $signed({7'd0, limit_q});
	always_comb begin
		if (vraw > lim_s) begin
			vcl = lim_s;
		end else if (vraw < -lim_s) begin
			vcl = -lim_s;
		end else begin
			vcl = vraw;
		end
		psum = 18'(x_q) + 18'(vcl);
		if (psum > 18'sd32767) begin
			npos_w = 16'sh7fff;
		end else if (psum < -18'sd32768) begin
			npos_w = 16'sh8000;
		end else begin
			npos_w = psum[15:0];
		end
		nvel_w = vcl[15:0];
		if (op_q == OpInit) begin
			npos_w = ipos_q;
			nvel_w = ivel_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			npos_q <= inr_q ? npos_w : '0;
			nvel_q <= inr_q ? nvel_w : '0;
			if (inr_q) begin
				pos_mem[elem_addr] <= npos_w;
				vel_mem[elem_addr] <= nvel_w;
			end
		end
		if (cmd.sum && inr_q && op_q == OpInit) begin
			pb_mem[elem_addr] <= ipos_q;
		end else if (cmd.copy && pimp_q) begin
			pb_mem[copy_addr] <= cp_rd_q;
		end
	end

	// Fitness sum and best tracking.
	logic [31:0] sq;
	logic [FitW:0] acc_sum;
	logic [FitW-1:0] acc_new;
	logic fit_p_lt, fit_g_lt;
	assign sq = 32'(npos_q * npos_q);
	assign acc_sum = {1'b0, acc_q} + (FitW+1)'(sq);
	assign acc_new = acc_sum[FitW] ? FitMax : acc_sum[FitW-1:0];
	assign fit_p_lt = acc_new < pbfit_q[p_q];
	assign fit_g_lt = acc_new < gbfit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			gbfit_q <= FitMax;
			for (int i = 0; i < NUM_PARTICLES; i++) begin
				pbfit_q[i] <= FitMax;
			end
			for (int k = 0; k < NUM_DIMS; k++) begin
				gbpos_q[k] <= '0;
			end
			done <= 1'b0;
			pimp_q <= 1'b0;
			gimp_q <= 1'b0;
			fit_q <= '0;
		end else begin
			done <= 1'b0;
			if (cmd.finish) begin
				done <= 1'b1;
				pimp_q <= 1'b0;
				gimp_q <= 1'b0;
				fit_q <= '0;
				if (inr_q) begin
					if (last_q) begin
						acc_q <= '0;
						fit_q <= acc_new;
						if (op_q == OpInit || fit_p_lt) begin
							pbfit_q[p_q] <= acc_new;
							pimp_q <= 1'b1;
						end
						if (fit_g_lt) begin
							gbfit_q <= acc_new;
							gimp_q <= 1'b1;
						end
					end else begin
						acc_q <= acc_new;
					end
				end
			end
			if (cmd.copy && gimp_q) begin
				gbpos_q[copy_dim] <= cp_rd_q;
			end
		end
	end

	// The global best position at the addressed dimension is read before the
	// copy sweep can change it, as it is sampled when the result is shown.
	assign gb_sel = dim_ok_q ? gbpos_q[d_q] : '0;

	assign stat.in_range = inr_q;
	assign stat.closes = inr_q && last_q;
	assign stat.is_update = (op_q == OpUpdate);
	assign stat.pimp = (op_q == OpInit) || fit_p_lt;
	assign stat.gimp = fit_g_lt;

	assign new_position = npos_q;
	assign new_velocity = nvel_q;
	assign fitness_valid = inr_q && last_q;
	assign particle_fitness = fit_q;
	assign personal_improved = pimp_q;
	assign global_improved = gimp_q;
	assign global_best_fitness = gbfit_q;
	// The copy of the addressed dimension lands after the strobe; show the
	// value that the copy will write when the global best changes.
	assign global_best_at_dim = (gimp_q && dim_ok_q) ? npos_q : gb_sel;

	`include "particle_swarm_update_assert.svh"
	`PSU_ASSERT_NEXT(a_done_after_finish, clk, arst_n, cmd.finish, done)
	`PSU_ASSERT_IMP(a_gimp_fit, clk, arst_n, done && global_improved,
		particle_fitness == global_best_fitness)
	`PSU_ASSERT_IMP(a_fit_flag, clk, arst_n, done && !fitness_valid, particle_fitness == '0)
endmodule

>>> rtl/particle_swarm_update.sv
// ----------------------------------------------------------------------------
// particle_swarm_update
// Particle swarm element update with sphere fitness and best tracking.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It passes through
// capture with element read, multiply, velocity sum, and fitness and best
// update before its result strobe, as the element memory reads and the
// products are registered. An item that improves a best keeps busy high
// after the strobe while it copies positions. The receiver cannot stall:
// each result is valid for the single cycle that done is high.
module particle_swarm_update #(
	parameter int NUM_PARTICLES = psu_pkg::NumParticlesDef,
	parameter int NUM_DIMS = psu_pkg::NumDimsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	input  logic cfg_we,
	input  logic [psu_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [psu_pkg::CfgW-1:0] cfg_data,
	input  logic op,
	input  logic [4:0] particle,
	input  logic dim,
	input  logic signed [15:0] init_position,
	input  logic signed [15:0] init_velocity,
	input  logic [15:0] rand_cog,
	input  logic [15:0] rand_soc,
	input  logic last_dim,
	output logic signed [15:0] new_position,
	output logic signed [15:0] new_velocity,
	output logic fitness_valid,
	output logic [34:0] particle_fitness,
	output logic personal_improved,
	output logic global_improved,
	output logic [34:0] global_best_fitness,
	output logic signed [15:0] global_best_at_dim
);
	import psu_pkg::*;

	localparam int DimW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	localparam int PartW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

	psu_cmd_t cmd;
	psu_stat_t stat;
	logic [DimW-1:0] copy_dim;
	logic fv, dn;

	psu_ctrl #(.NUM_DIMS(NUM_DIMS), .DimW(DimW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.busy(busy), .cmd(cmd), .copy_dim(copy_dim)
	);

	psu_datapath #(
		.NUM_PARTICLES(NUM_PARTICLES), .NUM_DIMS(NUM_DIMS),
		.PartW(PartW), .DimW(DimW)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .copy_dim(copy_dim), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.op(op), .particle(particle), .dim(dim),
		.init_position(init_position), .init_velocity(init_velocity),
		.rand_cog(rand_cog), .rand_soc(rand_soc), .last_dim(last_dim),
		.done(dn), .new_position(new_position), .new_velocity(new_velocity),
		.fitness_valid(fv), .particle_fitness(particle_fitness),
		.personal_improved(personal_improved), .global_improved(global_improved),
		.global_best_fitness(global_best_fitness),
		.global_best_at_dim(global_best_at_dim)
	);

	assign done = dn;
	assign fitness_valid = fv;
endmodule
